@@ hw/rtl/mhd_pkg.sv @@
// mhd_pkg: shared types, codes, constants and helper functions for the
// mecanum h-bridge drive block; used by every module in hw/rtl
package mhd_pkg;

  // trig table format, q1.TrigFracBits
  localparam int TrigFracBits = 15;
  localparam int TrigW        = TrigFracBits + 2;      // signed sine/cosine
  localparam int SumW         = TrigW + 1;             // signed sin +/- cos
  localparam int MulAW        = (SumW > 18) ? SumW : 18;
  localparam int MulBW        = 18;
  localparam int ProdW        = MulAW + MulBW;
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  // angle reduction: offset keeps the sum positive, reciprocal of 360 in q24
  localparam logic [16:0] AngleOffset = 17'd33120;     // 92 * 360
  localparam logic [17:0] Recip360    = 18'd46604;     // ceil(2^24 / 360)
  localparam int          Recip360Sh  = 24;

  localparam int InDataW  = 72;
  localparam int OutDataW = 72;

  typedef enum logic [2:0] {
    ACT_DRIVE     = 3'd0,
    ACT_ROTATE    = 3'd1,
    ACT_SET_SPEED = 3'd2,
    ACT_SET_MODE  = 3'd3,
    ACT_COAST_ALL = 3'd4,
    ACT_BRAKE_ALL = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    MODE_COAST   = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_BRAKE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_ID  = 2'd1,
    STATUS_BAD_MODE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in2;
    logic [7:0] in1;
  } motor_duty_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;
    logic mul_mod;
    logic rem;
    logic trig;
    logic mul_plus;
    logic mul_minus;
    logic apply;
  } dp_cmd_t;

  typedef logic [90:0][TrigFracBits:0] sin_tab_t;

  // first-quadrant sine table, taylor series in q30, built at elaboration
  function automatic sin_tab_t gen_sin_tab();
    sin_tab_t t;
    logic [63:0] x, x2, term, rnd;
    longint sum;
    int sh;
    sh = 30 - TrigFracBits;
    for (int d = 0; d <= 90; d++) begin
      x    = (64'(d) * PiQ30 + 64'd90) / 64'd180;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      rnd  = (64'(sum) + (64'd1 << (sh - 1))) >> sh;
      t[d] = rnd[TrigFracBits:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = gen_sin_tab();

  // signed sine of a reduced angle 0..359
  function automatic logic signed [TrigW-1:0] sin_deg(input logic [8:0] a);
    logic [8:0] idx;
    logic       neg;
    logic signed [TrigW-1:0] mag;
    neg = 1'b0;
    if (a <= 9'd90) idx = a;
    else if (a <= 9'd180) idx = 9'd180 - a;
    else if (a <= 9'd270) begin
      idx = a - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - a;
      neg = 1'b1;
    end
    mag = signed'(TrigW'(SinTab[idx[6:0]]));
    return neg ? -mag : mag;
  endfunction

  // pct 0..100 to duty pct*255/100 through a reciprocal
  function automatic logic [7:0] duty_of(input logic [6:0] pct);
    logic [22:0] p;
    p = 23'(pct) * 23'd41780;
    return p[21:14];
  endfunction

  function automatic motor_duty_t mode_pair(input mode_e m, input logic [6:0] pct);
    motor_duty_t r;
    r = '0;
    unique case (m)
      MODE_COAST:   r = '0;
      MODE_FORWARD: r.in1 = duty_of(pct);
      MODE_REVERSE: r.in2 = duty_of(pct);
      MODE_BRAKE:   r = '1;
      default:      r = '0;
    endcase
    return r;
  endfunction

  // signed percent, clamped to +/-100
  function automatic motor_duty_t signed_pair(input logic signed [16:0] s);
    logic signed [16:0] c;
    logic [16:0]        mag;
    c = s;
    if (c < -17'sd100) c = -17'sd100;
    if (c > 17'sd100) c = 17'sd100;
    mag = (c < 0) ? 17'(-c) : 17'(c);
    if (c == 0) return mode_pair(MODE_COAST, 7'd0);
    else if (c > 0) return mode_pair(MODE_FORWARD, mag[6:0]);
    else return mode_pair(MODE_REVERSE, mag[6:0]);
  endfunction

endpackage

@@ hw/rtl/mecanum_hbridge_drive.sv @@
// mecanum_hbridge_drive: top level, joins controller and datapath
// depends on mhd_pkg, mhd_ctrl, mhd_dp
//
// usage:
//   s_axis carries one motor command per transfer; tuser holds the action
//   (drive, rotate, set speed, set mode, coast all, brake all) and tdata the
//   operands. m_axis returns one result per command: the eight h-bridge pwm
//   duties after the command plus a status code.
// sequencing:
//   drive passes angle reduction, trig lookup, two products on the one
//   shared multiplier and the store update before m_axis_tvalid rises;
//   every other action goes straight to the store update. one command is in
//   work at a time and the input is ready again in the cycle the result is
//   loaded, so no new command is accepted until the last result is loaded.
// reset:
//   all duties clear (every motor coasts), no result pending.
// stall:
//   a result waits in the output register; the next command is accepted
//   and worked on meanwhile, and it holds before the store update until
//   the waiting result has been taken.
module mecanum_hbridge_drive import mhd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // motor_sel[2:0] mode[5:3] speed[21:6] angle[37:22] distance[53:38]
  // clockwise[54] degrees[70:55]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action[2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // m1_in1[7:0] m1_in2[15:8] m2_in1[23:16] m2_in2[31:24] m3_in1[39:32]
  // m3_in2[47:40] m4_in1[55:48] m4_in2[63:56] status[65:64]
  output logic [OutDataW-1:0] m_axis_tdata
);

  dp_cmd_t cmd;

  mhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mhd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cmd_i       (cmd),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ hw/rtl/mhd_ctrl.sv @@
// mhd_ctrl: command sequencer and output valid flag
// depends on mhd_pkg
module mhd_ctrl import mhd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_action_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MOD   = 7'b0000010,
    ST_REM   = 7'b0000100,
    ST_TRIG  = 7'b0001000,
    ST_MULP  = 7'b0010000,
    ST_MULM  = 7'b0100000,
    ST_APPLY = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == ACT_DRIVE) ? ST_MOD : ST_APPLY;
        end
      end
      ST_MOD: begin
        cmd_o.mul_mod = 1'b1;
        state_d       = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_TRIG;
      end
      ST_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.mul_plus = 1'b1;
        state_d        = ST_MULM;
      end
      ST_MULM: begin
        cmd_o.mul_minus = 1'b1;
        state_d         = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/mhd_dp.sv @@
// mhd_dp: command registers, shared multiplier, trig lookup, duty store
// and result register; depends on mhd_pkg
module mhd_dp import mhd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [2:0]          in_action_i,
  input  dp_cmd_t             cmd_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [2:0]  act_q;
  logic [2:0]  id_q;
  logic [2:0]  mode_q;
  logic signed [15:0] speed_q, angle_q, dist_q, deg_q;
  logic        cw_q;

  logic signed [ProdW-1:0] prod_q;
  logic [8:0]              ang_q;
  logic signed [SumW-1:0]  sum_q, diff_q;
  logic signed [16:0]      plus_q;
  motor_duty_t             duty_q [4];
  logic [OutDataW-1:0]     out_q;

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= in_action_i;
      id_q    <= in_data_i[2:0];
      mode_q  <= in_data_i[5:3];
      speed_q <= in_data_i[21:6];
      angle_q <= in_data_i[37:22];
      dist_q  <= in_data_i[53:38];
      cw_q    <= in_data_i[54];
      deg_q   <= in_data_i[70:55];
    end
  end

  // distance clamped to 0..100
  logic [6:0] dist_c;
  always_comb begin
    if (dist_q < 0) dist_c = 7'd0;
    else if (dist_q > 16'sd100) dist_c = 7'd100;
    else dist_c = dist_q[6:0];
  end

  // angle made positive, same residue mod 360
  logic [16:0] ang_v;
  assign ang_v = {angle_q[15], angle_q} + AngleOffset;

  // shared multiplier operand select
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_mod) begin
      mul_a = signed'(MulAW'(ang_v));
      mul_b = signed'(Recip360);
    end else if (cmd_i.mul_plus) begin
      mul_a = MulAW'(sum_q);
      mul_b = signed'(MulBW'(dist_c));
    end else if (cmd_i.mul_minus) begin
      mul_a = MulAW'(diff_q);
      mul_b = signed'(MulBW'(dist_c));
    end
  end
  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // product to percent, truncated toward zero
  logic [ProdW-1:0]   prod_mag;
  logic [7:0]         pct_mag;
  logic signed [16:0] pct_now;
  always_comb begin
    prod_mag = (prod_q < 0) ? ProdW'(-prod_q) : ProdW'(prod_q);
    pct_mag  = prod_mag[TrigFracBits +: 8];
    pct_now  = (prod_q < 0) ? -signed'(17'(pct_mag)) : signed'(17'(pct_mag));
  end

  // remainder and trig lookup
  logic [7:0]  quot;
  logic [16:0] rem_v;
  logic [8:0]  ang_c;
  logic signed [TrigW-1:0] s_val, c_val;
  always_comb begin
    quot  = prod_q[Recip360Sh +: 8];
    rem_v = ang_v - 17'(quot) * 17'd360;
    ang_c = (ang_q >= 9'd270) ? ang_q - 9'd270 : ang_q + 9'd90;
    s_val = sin_deg(ang_q);
    c_val = sin_deg(ang_c);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_mod || cmd_i.mul_plus || cmd_i.mul_minus) prod_q <= prod;
    if (cmd_i.rem) ang_q <= rem_v[8:0];
    if (cmd_i.trig) begin
      sum_q  <= SumW'(s_val) + SumW'(c_val);
      diff_q <= SumW'(s_val) - SumW'(c_val);
    end
    if (cmd_i.mul_minus) plus_q <= pct_now;
  end

  // rotate percent, degrees*100/180 through a reciprocal
  logic [7:0]         deg_c;
  logic [23:0]        rot_p;
  logic signed [16:0] rot_left;
  always_comb begin
    if (deg_q < 0) deg_c = 8'd0;
    else if (deg_q > 16'sd180) deg_c = 8'd180;
    else deg_c = deg_q[7:0];
    rot_p    = 24'(deg_c) * 24'd36409;
    rot_left = cw_q ? signed'(17'(rot_p[22:16])) : -signed'(17'(rot_p[22:16]));
  end

  // set-mode speed clamped to 0..100
  logic [6:0] spd_c;
  logic       id_ok;
  always_comb begin
    if (speed_q < 0) spd_c = 7'd0;
    else if (speed_q > 16'sd100) spd_c = 7'd100;
    else spd_c = speed_q[6:0];
    id_ok = (id_q >= 3'd1) && (id_q <= 3'd4);
  end

  // new duties for the command
  motor_duty_t duty_d [4];
  logic [1:0]  status_d;
  logic [1:0]  midx;
  always_comb begin
    for (int m = 0; m < 4; m++) duty_d[m] = duty_q[m];
    status_d = STATUS_OK;
    midx     = 2'(id_q - 3'd1);
    unique case (act_q)
      ACT_DRIVE: begin
        if (dist_c == 7'd0) begin
          for (int m = 0; m < 4; m++) duty_d[m] = '0;
        end else begin
          duty_d[0] = signed_pair(plus_q);
          duty_d[1] = signed_pair(pct_now);
          duty_d[2] = signed_pair(pct_now);
          duty_d[3] = signed_pair(plus_q);
        end
      end
      ACT_ROTATE: begin
        if (deg_c == 8'd0) begin
          for (int m = 0; m < 4; m++) duty_d[m] = '0;
        end else begin
          duty_d[0] = signed_pair(rot_left);
          duty_d[2] = signed_pair(rot_left);
          duty_d[1] = signed_pair(-rot_left);
          duty_d[3] = signed_pair(-rot_left);
        end
      end
      ACT_SET_SPEED: begin
        if (!id_ok) status_d = STATUS_BAD_ID;
        else duty_d[midx] = signed_pair(17'(speed_q));
      end
      ACT_SET_MODE: begin
        if (!id_ok) status_d = STATUS_BAD_ID;
        else if (mode_q[2]) status_d = STATUS_BAD_MODE;
        else duty_d[midx] = mode_pair(mode_e'(mode_q[1:0]), spd_c);
      end
      ACT_COAST_ALL: begin
        for (int m = 0; m < 4; m++) duty_d[m] = '0;
      end
      ACT_BRAKE_ALL: begin
        for (int m = 0; m < 4; m++) duty_d[m] = '1;
      end
      default: status_d = STATUS_OK;
    endcase
  end

  // duty store, all motors coast after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 4; m++) duty_q[m] <= '0;
    end else if (cmd_i.apply) begin
      for (int m = 0; m < 4; m++) duty_q[m] <= duty_d[m];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_q <= {6'd0, status_d, duty_d[3], duty_d[2], duty_d[1], duty_d[0]};
    end
  end
  assign out_data_o = out_q;

endmodule

@@ hw/rtl/mhd_checker.sv @@
// mhd_checker: port-level checks for mecanum_hbridge_drive, bound to it
// depends on mhd_pkg
module mhd_checker import mhd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [2:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // status code is never the unused value
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65:64] != 2'd3))
    else $error("unused status code on result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // brake all, taken with no result pending, shows full duty on every input
  a_brake_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == ACT_BRAKE_ALL) && !m_axis_tvalid
    |-> ##2 m_axis_tvalid && (m_axis_tdata[63:0] == '1)
        && (m_axis_tdata[65:64] == STATUS_OK))
    else $error("brake all result wrong");

  // set speed on motor id zero reports a bad id
  a_bad_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == ACT_SET_SPEED) && (s_axis_tdata[2:0] == 3'd0)
    && !m_axis_tvalid |-> ##2 m_axis_tvalid && (m_axis_tdata[65:64] == STATUS_BAD_ID))
    else $error("bad motor id not reported");

endmodule

bind mecanum_hbridge_drive mhd_checker u_mhd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
